FILE: design/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 message hash.
// No dependencies; imported by every module of the block.
`default_nettype none

package sha1_pkg;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_round;

    // Round variables a..e, also used for the chaining words
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    // Control from the sequencer to the schedule window
    typedef struct packed {
        logic shift;    // advance the window by one word
        logic ext;      // shift in the external word instead of the expanded one
    } t_win_ctrl;

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    localparam t_vars InitChain = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    localparam t_word PadWord  = 32'h80000000;
    localparam t_round LastRound = 7'd79;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // Boolean function of the round group
    function automatic t_word round_f(input t_round t, input t_word b, input t_word c,
                                      input t_word d);
        priority if (t < 7'd20) begin
            round_f = (b & c) | (~b & d);
        end else if (t < 7'd40) begin
            round_f = b ^ c ^ d;
        end else if (t < 7'd60) begin
            round_f = (b & c) | (b & d) | (c & d);
        end else begin
            round_f = b ^ c ^ d;
        end
    endfunction

    // Additive constant of the round group
    function automatic t_word round_k(input t_round t);
        priority if (t < 7'd20) begin
            round_k = K0;
        end else if (t < 7'd40) begin
            round_k = K1;
        end else if (t < 7'd60) begin
            round_k = K2;
        end else begin
            round_k = K3;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/sha1_window.sv
// Sixteen-word message schedule window, held as a shift line with fixed taps.
// Depends on sha1_pkg.
`default_nettype none

module sha1_window (
    input  wire                   i_clk,
    input  sha1_pkg::t_win_ctrl   i_ctrl,
    input  sha1_pkg::t_word       i_word,
    output sha1_pkg::t_word       o_w0
);
    import sha1_pkg::*;

    t_word r_win [16];
    t_word n_exp;

    // r_win[j] holds W[t+j]; the expanded word W[t+16] enters at the tail
    assign n_exp = rotl(r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0], 1);
    assign o_w0  = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= i_ctrl.ext ? i_word : n_exp;
        end
    end

endmodule

`default_nettype wire

FILE: design/sha1_round.sv
// One SHA-1 round: the shared unit the sequencer runs 80 times per block.
// Depends on sha1_pkg.
`default_nettype none

module sha1_round (
    input  sha1_pkg::t_round i_round,
    input  sha1_pkg::t_vars  i_vars,
    input  sha1_pkg::t_word  i_w,
    output sha1_pkg::t_vars  o_vars
);
    import sha1_pkg::*;

    t_word tmp;

    assign tmp = rotl(i_vars.a, 5) + round_f(i_round, i_vars.b, i_vars.c, i_vars.d)
               + i_vars.e + round_k(i_round) + i_w;

    always_comb begin
        o_vars.a = tmp;
        o_vars.b = i_vars.a;
        o_vars.c = rotl(i_vars.b, 30);
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

`default_nettype wire

FILE: design/sha1_message_hash.sv
// SHA-1 message hash top level: sequencer, chaining words, length and padding.
// Depends on sha1_pkg, sha1_window and sha1_round.
//
// Usage: drive a message word on i_msg_word with i_valid_bytes and
// i_end_of_message, raise start; the word is taken at a clock edge with
// start high and busy low. Words are big-endian; only the last word of a
// message may carry fewer than four bytes (counts above four read as four).
// A word that does not complete a 512-bit block and does not end the message
// leaves busy low. The sixteenth word of a block starts 80 rounds, one per
// cycle in the shared round unit, followed by the chaining add; busy stays
// high until the add is done. After the last word the block pads on its own,
// one pad word per cycle outside compressions, with one or two extra
// compressions, then drives the five digest words on o_digest_word on
// consecutive cycles, each marked by o_strobe, with o_digest_index 0..4 and
// o_digest_last on the fifth word. The receiver cannot stall the strobe. The
// chaining words, length and position then return to their initial values,
// ready for the next message.
// Reset (i_rst_n low, synchronous) drops any message in progress.
`default_nettype none

module sha1_message_hash (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  sha1_pkg::t_word    i_msg_word,
    input  wire [2:0]          i_valid_bytes,
    input  wire                i_end_of_message,
    output logic               o_strobe,
    output sha1_pkg::t_word    o_digest_word,
    output logic [2:0]         o_digest_index,
    output logic               o_digest_last
);
    import sha1_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  r_state, n_state;
    t_round      r_round, n_round;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_len, n_len;
    t_vars       r_chain, n_chain;
    t_vars       r_work, n_work;
    logic        r_in_pad, n_in_pad;
    logic        r_pad80, n_pad80;
    logic        r_hi_done, n_hi_done;
    logic        r_lo_done, n_lo_done;
    logic [2:0]  r_out_idx, n_out_idx;

    logic        accept;
    logic [2:0]  nbytes;
    t_word       mask;
    t_word       pad_bit;
    t_word       first_word;
    t_word       pad_word;
    t_word       push_word;
    t_win_ctrl   win_ctrl;
    t_word       w0;
    t_vars       round_out;
    t_word       out_sel;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign nbytes = (i_valid_bytes > 3'd4) ? 3'd4 : i_valid_bytes;

    // Tail masking and the 0x80 marker right after the last byte
    always_comb begin
        unique case (nbytes)
            3'd0:    begin mask = 32'h00000000; pad_bit = 32'h80000000; end
            3'd1:    begin mask = 32'hFF000000; pad_bit = 32'h00800000; end
            3'd2:    begin mask = 32'hFFFF0000; pad_bit = 32'h00008000; end
            3'd3:    begin mask = 32'hFFFFFF00; pad_bit = 32'h00000080; end
            default: begin mask = 32'hFFFFFFFF; pad_bit = 32'h00000000; end
        endcase
    end

    assign first_word = i_end_of_message ? ((i_msg_word & mask) | pad_bit) : i_msg_word;

    // Pad words: pending marker word, zeros, then length high and low
    always_comb begin
        priority if (r_pad80) begin
            pad_word = PadWord;
        end else if (r_pos == 4'd14) begin
            pad_word = r_len[63:32];
        end else if (r_pos == 4'd15 && r_hi_done) begin
            pad_word = r_len[31:0];
        end else begin
            pad_word = '0;
        end
    end

    assign push_word      = (r_state == ST_PAD) ? pad_word : first_word;
    assign win_ctrl.ext   = (r_state == ST_PAD) || accept;
    assign win_ctrl.shift = win_ctrl.ext || (r_state == ST_ROUND);

    sha1_window u_window (
        .i_clk  (i_clk),
        .i_ctrl (win_ctrl),
        .i_word (push_word),
        .o_w0   (w0)
    );

    sha1_round u_round (
        .i_round (r_round),
        .i_vars  (r_work),
        .i_w     (w0),
        .o_vars  (round_out)
    );

    // Digest word select
    always_comb begin
        unique case (r_out_idx)
            3'd0:    out_sel = r_chain.a;
            3'd1:    out_sel = r_chain.b;
            3'd2:    out_sel = r_chain.c;
            3'd3:    out_sel = r_chain.d;
            default: out_sel = r_chain.e;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_pos     = r_pos;
        n_len     = r_len;
        n_chain   = r_chain;
        n_work    = r_work;
        n_in_pad  = r_in_pad;
        n_pad80   = r_pad80;
        n_hi_done = r_hi_done;
        n_lo_done = r_lo_done;
        n_out_idx = r_out_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pos = r_pos + 4'd1;
                    if (i_end_of_message) begin
                        n_len    = r_len + {58'd0, nbytes, 3'b000};
                        n_in_pad = 1'b1;
                        n_pad80  = (nbytes == 3'd4);
                    end else begin
                        n_len = r_len + 64'd32;
                    end
                    if (r_pos == 4'd15) begin
                        n_state = ST_ROUND;
                        n_round = '0;
                        n_work  = r_chain;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_pos = r_pos + 4'd1;
                priority if (r_pad80) begin
                    n_pad80 = 1'b0;
                end else if (r_pos == 4'd14) begin
                    n_hi_done = 1'b1;
                end else if (r_pos == 4'd15 && r_hi_done) begin
                    n_lo_done = 1'b1;
                end else begin
                    n_pad80 = 1'b0;
                end
                if (r_pos == 4'd15) begin
                    n_state = ST_ROUND;
                    n_round = '0;
                    n_work  = r_chain;
                end
            end
            ST_ROUND: begin
                n_work  = round_out;
                n_round = r_round + 7'd1;
                if (r_round == LastRound) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_chain.a = r_chain.a + r_work.a;
                n_chain.b = r_chain.b + r_work.b;
                n_chain.c = r_chain.c + r_work.c;
                n_chain.d = r_chain.d + r_work.d;
                n_chain.e = r_chain.e + r_work.e;
                priority if (r_lo_done) begin
                    n_state   = ST_OUT;
                    n_out_idx = '0;
                end else if (r_in_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                n_out_idx = r_out_idx + 3'd1;
                if (r_out_idx == 3'd4) begin
                    n_state   = ST_IDLE;
                    n_chain   = InitChain;
                    n_len     = '0;
                    n_pos     = '0;
                    n_in_pad  = 1'b0;
                    n_pad80   = 1'b0;
                    n_hi_done = 1'b0;
                    n_lo_done = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_round   <= '0;
            r_pos     <= '0;
            r_len     <= '0;
            r_chain   <= InitChain;
            r_in_pad  <= 1'b0;
            r_pad80   <= 1'b0;
            r_hi_done <= 1'b0;
            r_lo_done <= 1'b0;
            r_out_idx <= '0;
            o_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_chain   <= n_chain;
            r_in_pad  <= n_in_pad;
            r_pad80   <= n_pad80;
            r_hi_done <= n_hi_done;
            r_lo_done <= n_lo_done;
            r_out_idx <= n_out_idx;
            o_strobe  <= (r_state == ST_OUT);
        end
    end

    // Round variables and digest output word, index and last flag
    always_ff @(posedge i_clk) begin
        r_work         <= n_work;
        o_digest_word  <= out_sel;
        o_digest_index <= r_out_idx;
        o_digest_last  <= (r_out_idx == 3'd4);
    end

    // Digest words come as an unbroken run 0..4 with nothing after the last
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_digest_last |=>
            o_strobe && (o_digest_index == $past(o_digest_index) + 3'd1))
        else $error("digest index did not advance");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_digest_last |=> !o_strobe)
        else $error("strobe after last digest word");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROUND |-> r_round <= LastRound)
        else $error("round counter out of range");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_in_pad && !r_lo_done)
        else $error("padding flags left set while idle");

    a_out_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |-> r_lo_done && r_pos == 4'd0)
        else $error("digest output before length word");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for sha1_message_hash: sends messages as words and checks each digest word.
// The predictor is a standalone SHA-1 with the block's padding rules.
// Depends on sha1_pkg and sha1_message_hash.
module testbench;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS = 10;

    // Chaining values and round constants, kept apart from the package
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] KR0 = 32'h5A827999;
    localparam logic [31:0] KR1 = 32'h6ED9EBA1;
    localparam logic [31:0] KR2 = 32'h8F1BBCDC;
    localparam logic [31:0] KR3 = 32'hCA62C1D6;
    localparam logic [31:0] PAD_BYTE_WORD = 32'h8000_0000;
    localparam int unsigned LENGTH_SLOT = 14;

    typedef struct packed {
        sha1_pkg::t_word word;
        logic [2:0]      index;
        logic            last;
    } t_digest_entry;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    sha1_pkg::t_word i_msg_word;
    logic [2:0]      i_valid_bytes;
    logic            i_end_of_message;
    logic            o_strobe;
    sha1_pkg::t_word o_digest_word;
    logic [2:0]      o_digest_index;
    logic            o_digest_last;

    // Predictor state
    logic [31:0]     hash_chain [5];
    logic [31:0]     sched [16];
    int unsigned     fill;
    logic [63:0]     msg_bits;

    t_digest_entry   expected_digest [$];
    t_digest_entry   want;
    int unsigned     error_count = 0;
    int unsigned     words_sent;
    int unsigned     stall_cycles = 0;
    bit              idle_on;

    sha1_message_hash u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_msg_word       (i_msg_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_end_of_message (i_end_of_message),
        .o_strobe         (o_strobe),
        .o_digest_word    (o_digest_word),
        .o_digest_index   (o_digest_index),
        .o_digest_last    (o_digest_last)
    );

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        hash_chain[0] = H0;
        hash_chain[1] = H1;
        hash_chain[2] = H2;
        hash_chain[3] = H3;
        hash_chain[4] = H4;
        fill = 0;
        msg_bits = '0;
    endfunction

    // 80 rounds over the full window, schedule expanded in place
    function automatic void compress_window();
        logic [31:0] a, b, c, d, e, f, k, w, sum;
        int unsigned r;
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = rot_left(sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^
                             sched[(r + 2) & 15] ^ sched[r & 15], 1);
                sched[r & 15] = w;
            end else begin
                w = sched[r];
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = KR0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = KR1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = KR2;
            end else begin
                f = b ^ c ^ d;
                k = KR3;
            end
            sum = rot_left(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rot_left(b, 30);
            b = a;
            a = sum;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        sched[fill] = w;
        fill++;
        if (fill == 16) begin
            compress_window();
            fill = 0;
        end
    endfunction

    // Update the hash with one accepted word; a last word queues the digest
    function automatic void predict_word(input sha1_pkg::t_word w, input logic [2:0] nb_in,
                                         input logic eom);
        int unsigned   nb;
        int unsigned   i;
        logic [31:0]   mask;
        t_digest_entry ent;
        if (!eom) begin
            msg_bits += 64'd32;
            absorb_word(w);
            return;
        end
        nb = (nb_in > 3'd4) ? 4 : int'(nb_in);
        msg_bits += 64'(nb * 8);
        if (nb == 4) begin
            absorb_word(w);
            absorb_word(PAD_BYTE_WORD);
        end else begin
            mask = (nb == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nb));
            absorb_word((w & mask) | (32'h80 << (24 - 8 * nb)));
        end
        // no room left for the length: close this block with zeros
        if (fill > LENGTH_SLOT) begin
            while (fill != 0) absorb_word(32'h0);
        end
        while (fill < LENGTH_SLOT) absorb_word(32'h0);
        absorb_word(msg_bits[63:32]);
        absorb_word(msg_bits[31:0]);
        for (i = 0; i < 5; i++) begin
            ent.word  = hash_chain[i];
            ent.index = 3'(i);
            ent.last  = (i == 4);
            expected_digest.push_back(ent);
        end
        restart_hash();
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_digest.size() == 0) begin
                flag_error($sformatf("digest word %h idx %0d with nothing expected",
                                     o_digest_word, o_digest_index));
            end else begin
                want = expected_digest.pop_front();
                if (o_digest_word !== want.word || o_digest_index !== want.index ||
                    o_digest_last !== want.last) begin
                    flag_error($sformatf("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                         want.word, want.index, want.last,
                                         o_digest_word, o_digest_index, o_digest_last));
                end
            end
        end
    end

    // Watchdog: cycles with neither a word taken nor a digest word out
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Hold start high until a word is taken; start stays high on return
    task automatic send_word(input sha1_pkg::t_word w, input logic [2:0] nb, input logic eom);
        start            <= 1'b1;
        i_msg_word       <= w;
        i_valid_bytes    <= nb;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_word(w, nb, eom);
        words_sent++;
    endtask

    // Sender gap with start low and noise on the word fields
    task automatic idle_sender(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) begin
            i_msg_word       <= $urandom;
            i_valid_bytes    <= 3'($urandom_range(0, 7));
            i_end_of_message <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 14));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_digest.size() != 0);
    endtask

    function automatic sha1_pkg::t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // n_full full words, then the last word with the given byte count
    task automatic send_message(input int unsigned n_full, input logic [2:0] last_nb);
        int unsigned i;
        logic [2:0]  nb;
        for (i = 0; i < n_full; i++) begin
            // count on a non-last word is ignored, so vary it now and then
            nb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_word(pick_word(), nb, 1'b0);
            maybe_idle();
        end
        send_word(pick_word(), last_nb, 1'b1);
        maybe_idle();
    endtask

    task automatic send_random_message();
        int unsigned n_full;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n_full = $urandom_range(0, 3);
            4, 5, 6:    n_full = $urandom_range(12, 16);   // tails near the length slot
            7, 8:       n_full = $urandom_range(4, 31);
            default:    n_full = $urandom_range(32, 48);
        endcase
        send_message(n_full, 3'($urandom_range(0, 7)));
    endtask

    // ---------------------------------------------------------------- tests

    // Empty message: junk in a zero-byte last word must hash as the empty string
    task automatic test_empty_message();
        send_word(32'hDEAD_BEEF, 3'd0, 1'b1);
        maybe_idle();
    endtask

    // One-word messages of 1..4 bytes, unused bytes filled with ones
    task automatic test_short_tails();
        send_word(32'h6162_63FF, 3'd3, 1'b1);
        maybe_idle();
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        maybe_idle();
        send_word(32'h0000_FFFF, 3'd2, 1'b1);
        maybe_idle();
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        maybe_idle();
    endtask

    // Byte counts above four on a last word read as four
    task automatic test_count_above_four();
        send_word(32'h0000_0000, 3'd5, 1'b1);
        maybe_idle();
        send_word(32'hA5A5_5A5A, 3'd6, 1'b1);
        maybe_idle();
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
        maybe_idle();
    endtask

    // 56-byte message: pad byte fills slot 14, length spills to an extra block
    task automatic test_long_tail();
        send_message(13, 3'd4);
    endtask

    task automatic test_random_messages();
        int unsigned n_msgs;
        n_msgs = 0;
        while (words_sent < 125) begin
            send_random_message();
            n_msgs++;
            // hold off once until every digest word is out
            if (n_msgs == 5) drain_results();
        end
    endtask

    // Closing stretch with the sender never pausing, at least one message long
    task automatic test_back_to_back();
        idle_on = 1'b0;
        do send_random_message(); while (words_sent < 155);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_msg_word       <= '0;
        i_valid_bytes    <= '0;
        i_end_of_message <= 1'b0;
        words_sent   = 0;
        idle_on      = 1'b1;
        restart_hash();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_short_tails();
        test_count_above_four();
        test_long_tail();
        test_random_messages();
        test_back_to_back();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_digest.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sha1_pkg.sv
design/sha1_window.sv
design/sha1_round.sv
design/sha1_message_hash.sv
tb/testbench.sv
